// ===== hdl/sha512_compression_core_unit_assert.svh =====
// assertion macros shared by the sha-512 compression core
`ifndef SHA512_COMPRESSION_CORE_UNIT_ASSERT_SVH
`define SHA512_COMPRESSION_CORE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SHA512CC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SHA512CC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sha512cc_pkg.sv =====
// types, constants and round functions of the sha-512 compression core
`default_nettype none
package sha512cc_pkg;

	localparam int unsigned WORD_W      = 64;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS      = 80;
	localparam int unsigned HASH_WORDS  = 8;
	localparam int unsigned CNT_W       = $clog2(BLOCK_WORDS);
	localparam int unsigned ROUND_W     = $clog2(ROUNDS);
	localparam int unsigned IDX_W       = $clog2(HASH_WORDS);
	localparam int unsigned OUT_DATA_W  = 72;

	localparam logic [CNT_W-1:0]   LAST_WORD  = CNT_W'(BLOCK_WORDS - 1);
	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
	localparam logic [IDX_W-1:0]   LAST_IDX_384 = IDX_W'(5);
	localparam logic [IDX_W-1:0]   LAST_IDX_512 = IDX_W'(7);

	localparam logic MODE_384 = 1'b0;
	localparam logic MODE_512 = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                shift_word;
		logic                load_iv;
		logic                iv_sel;
		logic                init_vars;
		logic                round_en;
		logic [ROUND_W-1:0]  round;
		logic                add_hash;
		logic [IDX_W-1:0]    out_idx;
	} cmd_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic word_t iv_word(input logic sel, input logic [IDX_W-1:0] i);
		word_t v;
		v = '0;
		if (sel == MODE_512) begin
			unique case (i)
				3'd0: v = 64'h6A09E667F3BCC908;
				3'd1: v = 64'hBB67AE8584CAA73B;
				3'd2: v = 64'h3C6EF372FE94F82B;
				3'd3: v = 64'hA54FF53A5F1D36F1;
				3'd4: v = 64'h510E527FADE682D1;
				3'd5: v = 64'h9B05688C2B3E6C1F;
				3'd6: v = 64'h1F83D9ABFB41BD6B;
				3'd7: v = 64'h5BE0CD19137E2179;
			endcase
		end else begin
			unique case (i)
				3'd0: v = 64'hCBBB9D5DC1059ED8;
				3'd1: v = 64'h629A292A367CD507;
				3'd2: v = 64'h9159015A3070DD17;
				3'd3: v = 64'h152FECD8F70E5939;
				3'd4: v = 64'h67332667FFC00B31;
				3'd5: v = 64'h8EB44A8768581511;
				3'd6: v = 64'hDB0C2E0D64F98FA7;
				3'd7: v = 64'h47B5481DBEFA4FA4;
			endcase
		end
		iv_word = v;
	endfunction

	function automatic word_t round_k(input logic [ROUND_W-1:0] r);
		word_t k;
		unique case (r)
			7'd0:  k = 64'h428A2F98D728AE22;
			7'd1:  k = 64'h7137449123EF65CD;
			7'd2:  k = 64'hB5C0FBCFEC4D3B2F;
			7'd3:  k = 64'hE9B5DBA58189DBBC;
			7'd4:  k = 64'h3956C25BF348B538;
			7'd5:  k = 64'h59F111F1B605D019;
			7'd6:  k = 64'h923F82A4AF194F9B;
			7'd7:  k = 64'hAB1C5ED5DA6D8118;
			7'd8:  k = 64'hD807AA98A3030242;
			7'd9:  k = 64'h12835B0145706FBE;
			7'd10: k = 64'h243185BE4EE4B28C;
			7'd11: k = 64'h550C7DC3D5FFB4E2;
			7'd12: k = 64'h72BE5D74F27B896F;
			7'd13: k = 64'h80DEB1FE3B1696B1;
			7'd14: k = 64'h9BDC06A725C71235;
			7'd15: k = 64'hC19BF174CF692694;
			7'd16: k = 64'hE49B69C19EF14AD2;
			7'd17: k = 64'hEFBE4786384F25E3;
			7'd18: k = 64'h0FC19DC68B8CD5B5;
			7'd19: k = 64'h240CA1CC77AC9C65;
			7'd20: k = 64'h2DE92C6F592B0275;
			7'd21: k = 64'h4A7484AA6EA6E483;
			7'd22: k = 64'h5CB0A9DCBD41FBD4;
			7'd23: k = 64'h76F988DA831153B5;
			7'd24: k = 64'h983E5152EE66DFAB;
			7'd25: k = 64'hA831C66D2DB43210;
			7'd26: k = 64'hB00327C898FB213F;
			7'd27: k = 64'hBF597FC7BEEF0EE4;
			7'd28: k = 64'hC6E00BF33DA88FC2;
			7'd29: k = 64'hD5A79147930AA725;
			7'd30: k = 64'h06CA6351E003826F;
			7'd31: k = 64'h142929670A0E6E70;
			7'd32: k = 64'h27B70A8546D22FFC;
			7'd33: k = 64'h2E1B21385C26C926;
			7'd34: k = 64'h4D2C6DFC5AC42AED;
			7'd35: k = 64'h53380D139D95B3DF;
			7'd36: k = 64'h650A73548BAF63DE;
			7'd37: k = 64'h766A0ABB3C77B2A8;
			7'd38: k = 64'h81C2C92E47EDAEE6;
			7'd39: k = 64'h92722C851482353B;
			7'd40: k = 64'hA2BFE8A14CF10364;
			7'd41: k = 64'hA81A664BBC423001;
			7'd42: k = 64'hC24B8B70D0F89791;
			7'd43: k = 64'hC76C51A30654BE30;
			7'd44: k = 64'hD192E819D6EF5218;
			7'd45: k = 64'hD69906245565A910;
			7'd46: k = 64'hF40E35855771202A;
			7'd47: k = 64'h106AA07032BBD1B8;
			7'd48: k = 64'h19A4C116B8D2D0C8;
			7'd49: k = 64'h1E376C085141AB53;
			7'd50: k = 64'h2748774CDF8EEB99;
			7'd51: k = 64'h34B0BCB5E19B48A8;
			7'd52: k = 64'h391C0CB3C5C95A63;
			7'd53: k = 64'h4ED8AA4AE3418ACB;
			7'd54: k = 64'h5B9CCA4F7763E373;
			7'd55: k = 64'h682E6FF3D6B2B8A3;
			7'd56: k = 64'h748F82EE5DEFB2FC;
			7'd57: k = 64'h78A5636F43172F60;
			7'd58: k = 64'h84C87814A1F0AB72;
			7'd59: k = 64'h8CC702081A6439EC;
			7'd60: k = 64'h90BEFFFA23631E28;
			7'd61: k = 64'hA4506CEBDE82BDE9;
			7'd62: k = 64'hBEF9A3F7B2C67915;
			7'd63: k = 64'hC67178F2E372532B;
			7'd64: k = 64'hCA273ECEEA26619C;
			7'd65: k = 64'hD186B8C721C0C207;
			7'd66: k = 64'hEADA7DD6CDE0EB1E;
			7'd67: k = 64'hF57D4F7FEE6ED178;
			7'd68: k = 64'h06F067AA72176FBA;
			7'd69: k = 64'h0A637DC5A2C898A6;
			7'd70: k = 64'h113F9804BEF90DAE;
			7'd71: k = 64'h1B710B35131C471B;
			7'd72: k = 64'h28DB77F523047D84;
			7'd73: k = 64'h32CAAB7B40C72493;
			7'd74: k = 64'h3C9EBE0A15C9BEBC;
			7'd75: k = 64'h431D67C49C100D4C;
			7'd76: k = 64'h4CC5D4BECB3E42B6;
			7'd77: k = 64'h597F299CFC657E2A;
			7'd78: k = 64'h5FCB6FAB3AD6FAEC;
			7'd79: k = 64'h6C44198C4A475817;
			default: k = '0;
		endcase
		round_k = k;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/sha512_compression_core_unit.sv =====
// top level of the sha-384/sha-512 compression core
//
// channel   direction  tdata                          tuser                      tlast
// s_axis    in         [63:0] message_word             [0] first_block [1] last   -
// m_axis    out        [63:0] digest_word [66:64] idx  -                          digest_last
// cfg       in         cfg_wdata = digest_mode, written when cfg_we is high
//
// a block of 16 words is taken at one word per cycle while s_axis_tvalid is high, then
// the shared round unit runs 80 rounds at one per cycle and ST_FINAL adds into the hash state
// no input is taken during the rounds or while digest words are offered
// digest words go out one per accepted output transaction, 6 or 8 of them
// reset clears the controller, the mode (sha-512) and the hash state
`default_nettype none
module sha512_compression_core_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic                                  cfg_wdata,
	input  wire logic                                  s_axis_tvalid,
	output      logic                                  s_axis_tready,
	input  wire logic [sha512cc_pkg::WORD_W-1:0]       s_axis_tdata,  // message_word
	input  wire logic [1:0]                            s_axis_tuser,  // first_block, last_block
	output      logic                                  m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output      logic [sha512cc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // digest_word, digest_index
	output      logic                                  m_axis_tlast   // digest_last
);

	`include "sha512_compression_core_unit_assert.svh"

	sha512cc_pkg::cmd_t  cmd;
	sha512cc_pkg::word_t digest_word;

	sha512cc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_first  (s_axis_tuser[0]),
		.in_last   (s_axis_tuser[1]),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_last  (m_axis_tlast),
		.cmd       (cmd)
	);

	sha512cc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_word (s_axis_tdata),
		.digest_word  (digest_word)
	);

	assign m_axis_tdata = {
		(sha512cc_pkg::OUT_DATA_W - sha512cc_pkg::WORD_W - sha512cc_pkg::IDX_W)'(0),
		cmd.out_idx,
		digest_word
	};

	`SHA512CC_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid && !cmd.round_en, "input open during rounds or output")
	`SHA512CC_ASSERT_NOW(a_last_index, m_axis_tvalid && m_axis_tlast, (m_axis_tdata[66:64] == 3'd5) || (m_axis_tdata[66:64] == 3'd7), "digest ends at wrong index")
	`SHA512CC_ASSERT_NEXT(a_block_starts_rounds, cmd.init_vars, cmd.round_en && (cmd.round == '0) && !s_axis_tready, "block end did not start rounds")
	`SHA512CC_ASSERT_NEXT(a_digest_done, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid && s_axis_tready, "output did not close after last digest word")

endmodule
`default_nettype wire

// ===== hdl/sha512cc_dpath.sv =====
// datapath: schedule window, working variables, hash state and digest select
`default_nettype none
module sha512cc_dpath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire sha512cc_pkg::cmd_t               cmd,
	input  wire sha512cc_pkg::word_t              message_word,
	output      sha512cc_pkg::word_t              digest_word
);

	sha512cc_pkg::word_t win_q  [sha512cc_pkg::BLOCK_WORDS];
	sha512cc_pkg::word_t vars_q [sha512cc_pkg::HASH_WORDS];
	sha512cc_pkg::word_t hash_q [sha512cc_pkg::HASH_WORDS];

	sha512cc_pkg::word_t w_next;
	sha512cc_pkg::word_t t1;
	sha512cc_pkg::word_t t2;
	sha512cc_pkg::word_t ch;
	sha512cc_pkg::word_t maj;

	// next schedule word from fixed taps of the sliding window
	assign w_next = sha512cc_pkg::small_sigma1(win_q[14]) + win_q[9]
		+ sha512cc_pkg::small_sigma0(win_q[1]) + win_q[0];

	assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
	assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
	assign t1  = vars_q[7] + sha512cc_pkg::big_sigma1(vars_q[4]) + ch
		+ sha512cc_pkg::round_k(cmd.round) + win_q[0];
	assign t2  = sha512cc_pkg::big_sigma0(vars_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (cmd.shift_word || cmd.round_en) begin
			for (int i = 0; i < sha512cc_pkg::BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sha512cc_pkg::BLOCK_WORDS-1] <= cmd.shift_word ? message_word : w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_vars) begin
			for (int i = 0; i < sha512cc_pkg::HASH_WORDS; i++) begin
				vars_q[i] <= hash_q[i];
			end
		end else if (cmd.round_en) begin
			vars_q[7] <= vars_q[6];
			vars_q[6] <= vars_q[5];
			vars_q[5] <= vars_q[4];
			vars_q[4] <= vars_q[3] + t1;
			vars_q[3] <= vars_q[2];
			vars_q[2] <= vars_q[1];
			vars_q[1] <= vars_q[0];
			vars_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha512cc_pkg::HASH_WORDS; i++) begin
				hash_q[i] <= '0;
			end
		end else if (cmd.load_iv) begin
			for (int i = 0; i < sha512cc_pkg::HASH_WORDS; i++) begin
				hash_q[i] <= sha512cc_pkg::iv_word(cmd.iv_sel, sha512cc_pkg::IDX_W'(i));
			end
		end else if (cmd.add_hash) begin
			for (int i = 0; i < sha512cc_pkg::HASH_WORDS; i++) begin
				hash_q[i] <= hash_q[i] + vars_q[i];
			end
		end
	end

	assign digest_word = hash_q[cmd.out_idx];

endmodule
`default_nettype wire

// ===== hdl/sha512cc_ctrl.sv =====
// controller: word and round counters, mode register and sequencing
`default_nettype none
module sha512cc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	input  wire logic                 in_valid,
	input  wire logic                 in_first,
	input  wire logic                 in_last,
	output      logic                 in_ready,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 out_last,
	output      sha512cc_pkg::cmd_t   cmd
);

	sha512cc_pkg::state_t                 state_q;
	sha512cc_pkg::state_t                 state_d;
	logic [sha512cc_pkg::CNT_W-1:0]       word_cnt_q;
	logic [sha512cc_pkg::ROUND_W-1:0]     round_q;
	logic [sha512cc_pkg::IDX_W-1:0]       out_idx_q;
	logic                                 last_blk_q;
	logic                                 mode_q;
	logic                                 in_acc;
	logic                                 out_acc;
	logic                                 block_end;

	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign block_end = in_acc && (word_cnt_q == sha512cc_pkg::LAST_WORD);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha512cc_pkg::ST_LOAD: begin
				if (block_end) begin
					state_d = sha512cc_pkg::ST_ROUND;
				end
			end
			sha512cc_pkg::ST_ROUND: begin
				if (round_q == sha512cc_pkg::LAST_ROUND) begin
					state_d = sha512cc_pkg::ST_FINAL;
				end
			end
			sha512cc_pkg::ST_FINAL: begin
				state_d = last_blk_q ? sha512cc_pkg::ST_OUT : sha512cc_pkg::ST_LOAD;
			end
			sha512cc_pkg::ST_OUT: begin
				if (out_acc && out_last) begin
					state_d = sha512cc_pkg::ST_LOAD;
				end
			end
		endcase
	end

	always_comb begin
		in_ready  = (state_q == sha512cc_pkg::ST_LOAD);
		out_valid = (state_q == sha512cc_pkg::ST_OUT);
		out_last  = (mode_q == sha512cc_pkg::MODE_512) ?
			(out_idx_q == sha512cc_pkg::LAST_IDX_512) :
			(out_idx_q == sha512cc_pkg::LAST_IDX_384);
		cmd.shift_word = in_acc;
		cmd.load_iv    = in_acc && in_first && (word_cnt_q == '0);
		cmd.iv_sel     = mode_q;
		cmd.init_vars  = block_end;
		cmd.round_en   = (state_q == sha512cc_pkg::ST_ROUND);
		cmd.round      = round_q;
		cmd.add_hash   = (state_q == sha512cc_pkg::ST_FINAL);
		cmd.out_idx    = out_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sha512cc_pkg::ST_LOAD;
			word_cnt_q <= '0;
			round_q    <= '0;
			out_idx_q  <= '0;
			last_blk_q <= 1'b0;
			mode_q     <= sha512cc_pkg::MODE_512;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (in_acc) begin
				word_cnt_q <= word_cnt_q + 1'b1;
			end
			// last flag counts only on the word that completes the block
			if (block_end) begin
				last_blk_q <= in_last;
			end
			if (state_q == sha512cc_pkg::ST_ROUND) begin
				round_q <= (round_q == sha512cc_pkg::LAST_ROUND) ? '0 : round_q + 1'b1;
			end
			if (state_q == sha512cc_pkg::ST_FINAL) begin
				out_idx_q <= '0;
			end else if (out_acc) begin
				out_idx_q <= out_idx_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire
